[sv/rcdt_pkg.sv]
// Package for the reference-counted dedup table: sizes, status codes,
// request/response beat types and the stored entry layout.
// No dependencies.
`default_nettype none

package rcdt_pkg;

   localparam int ENTRIES    = 64;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int HW_BITS    = IDX_BITS + 1;
   localparam int KEY_BITS   = 64;
   localparam int COUNT_BITS = 16;
   localparam int STAT_BITS  = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [HW_BITS-1:0]    HW_FULL   = HW_BITS'(ENTRIES);

   // command codes
   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // response status codes
   localparam logic [STAT_BITS-1:0] STAT_HIT       = 3'd0;
   localparam logic [STAT_BITS-1:0] STAT_NEW       = 3'd1;
   localparam logic [STAT_BITS-1:0] STAT_HELD      = 3'd2;
   localparam logic [STAT_BITS-1:0] STAT_FREED     = 3'd3;
   localparam logic [STAT_BITS-1:0] STAT_FULL      = 3'd4;
   localparam logic [STAT_BITS-1:0] STAT_IGNORED   = 3'd5;
   localparam logic [STAT_BITS-1:0] STAT_SATURATED = 3'd6;

   typedef struct packed {
      logic                command;
      logic [KEY_BITS-1:0] key;
      logic [IDX_BITS-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]   entry;
      logic [STAT_BITS-1:0]  status;
      logic [COUNT_BITS-1:0] count_after;
   } rsp_type;

   // one table slot as held in memory
   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

endpackage

`default_nettype wire

[sv/rcdt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module rcdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port, then registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[sv/refcounted_dedup_table.sv]
// Reference-counted dedup table, top level. Depends on rcdt_pkg and rcdt_ram.
// Acquire: S_SCAN reads slots from 0 up to the high-water mark (hw), one slot read per
//   cycle, ending early on a hit; the registered result strobe then shows in S_RESP.
// Release: S_REL updates the slot, strobe shows in S_RESP; no new accept until S_IDLE.
// The receiver cannot stall; each result shows for one cycle on rsp_strobe.
// Synchronous reset clears the high-water mark, so the table starts empty at once.
`default_nettype none

module refcounted_dedup_table (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire rcdt_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output rcdt_pkg::rsp_type     rsp_item
);

   import rcdt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_REL  = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [HW_BITS-1:0]  hw_ff, hw_in;
   logic [IDX_BITS-1:0] free_ff, free_in;
   logic                have_free_ff, have_free_in;
   req_type             req_ff, req_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   logic                ram_wr;
   logic [IDX_BITS-1:0] ram_wr_addr;
   entry_type           ram_wr_data;
   logic [IDX_BITS-1:0] ram_rd_addr;
   entry_type           ram_rd_data;

   logic                accept;
   logic                in_range;
   logic                is_free;
   logic                is_hit;
   logic                is_last;
   logic [HW_BITS-1:0]  idx_next_wide;
   logic [COUNT_BITS-1:0] count_dec;

   rcdt_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(ENTRIES)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_wr),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign accept     = start && !busy;
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // classify the slot whose data arrives this cycle
   assign idx_next_wide = {1'b0, idx_ff} + HW_BITS'(1);
   assign in_range      = ({1'b0, idx_ff} < hw_ff);
   assign is_free       = in_range && (ram_rd_data.count == '0);
   assign is_hit        = in_range && !is_free && (ram_rd_data.key == req_ff.key);
   assign is_last       = !in_range || (idx_next_wide >= hw_ff);
   assign count_dec     = ram_rd_data.count - COUNT_ONE;

   // read address: first slot or release slot on accept, next slot while scanning
   always_comb begin
      unique case (state_ff)
         S_IDLE:  ram_rd_addr = (req_item.command == CMD_RELEASE) ? req_item.slot : '0;
         S_SCAN:  ram_rd_addr = idx_next_wide[IDX_BITS-1:0];
         default: ram_rd_addr = idx_ff;
      endcase
   end

   // sequencer: scan, allocate, release, respond
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      hw_in         = hw_ff;
      free_in       = free_ff;
      have_free_in  = have_free_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      ram_wr        = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = ram_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in       = req_item;
               idx_in       = (req_item.command == CMD_RELEASE) ? req_item.slot : '0;
               have_free_in = 1'b0;
               free_in      = '0;
               state_in     = (req_item.command == CMD_RELEASE) ? S_REL : S_SCAN;
            end
         end

         S_SCAN: begin
            if (is_hit) begin
               // raise the count, or hold it at the maximum
               rsp_in.entry = idx_ff;
               if (ram_rd_data.count == COUNT_MAX) begin
                  rsp_in.status      = STAT_SATURATED;
                  rsp_in.count_after = COUNT_MAX;
               end else begin
                  ram_wr                = 1'b1;
                  ram_wr_data.count     = ram_rd_data.count + COUNT_ONE;
                  rsp_in.status         = STAT_HIT;
                  rsp_in.count_after    = ram_rd_data.count + COUNT_ONE;
               end
               rsp_strobe_in = 1'b1;
               state_in      = S_RESP;
            end else if (is_last) begin
               // miss: reuse the highest free slot, else append, else full
               ram_wr_data.key   = req_ff.key;
               ram_wr_data.count = COUNT_ONE;
               rsp_in.status      = STAT_NEW;
               rsp_in.count_after = COUNT_ONE;
               if (is_free) begin
                  ram_wr       = 1'b1;
                  ram_wr_addr  = idx_ff;
                  rsp_in.entry = idx_ff;
               end else if (have_free_ff) begin
                  ram_wr       = 1'b1;
                  ram_wr_addr  = free_ff;
                  rsp_in.entry = free_ff;
               end else if (hw_ff == HW_FULL) begin
                  rsp_in.entry       = '0;
                  rsp_in.status      = STAT_FULL;
                  rsp_in.count_after = '0;
               end else begin
                  ram_wr       = 1'b1;
                  ram_wr_addr  = hw_ff[IDX_BITS-1:0];
                  rsp_in.entry = hw_ff[IDX_BITS-1:0];
                  hw_in        = hw_ff + HW_BITS'(1);
               end
               rsp_strobe_in = 1'b1;
               state_in      = S_RESP;
            end else begin
               // advance to the next slot, remember the latest free one
               if (is_free) begin
                  free_in      = idx_ff;
                  have_free_in = 1'b1;
               end
               idx_in = idx_next_wide[IDX_BITS-1:0];
            end
         end

         S_REL: begin
            // lower the count of a live slot, drop anything else
            rsp_in.entry = idx_ff;
            if (is_free || !in_range) begin
               rsp_in.status      = STAT_IGNORED;
               rsp_in.count_after = '0;
            end else begin
               ram_wr             = 1'b1;
               ram_wr_data.count  = count_dec;
               rsp_in.status      = (count_dec == '0) ? STAT_FREED : STAT_HELD;
               rsp_in.count_after = count_dec;
            end
            rsp_strobe_in = 1'b1;
            state_in      = S_RESP;
         end

         S_RESP: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hw_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hw_ff         <= hw_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      free_ff      <= free_in;
      have_free_ff <= have_free_in;
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
   end

   // the mark never passes the table size
   assert property (@(posedge clock) disable iff (reset) hw_ff <= HW_FULL)
      else $error("high-water mark above table size");

   // a result beat is followed by an idle block
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> (state_ff == S_IDLE))
      else $error("block not idle after result beat");

   // an accepted beat makes the block busy
   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("block not busy after accept");

   // memory writes happen only while working on a beat
   assert property (@(posedge clock) disable iff (reset)
      ram_wr |-> (state_ff == S_SCAN || state_ff == S_REL))
      else $error("memory write outside scan or release");

   // a new entry starts with a count of one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.status == STAT_NEW) |-> (rsp_ff.count_after == COUNT_ONE))
      else $error("new entry with count other than one");

endmodule

`default_nettype wire
